>>> rtl/tdpt_pkg.sv
package tdpt_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH);

   typedef struct packed {
      logic load;
      logic step;
      logic next;
   } tdpt_cmd_type;

   typedef struct packed {
      logic trivial_no;
      logic div_last;
      logic bound_fail;
      logic rem_zero;
   } tdpt_status_type;

endpackage

>>> rtl/tdpt_datapath.sv
module tdpt_datapath
   import tdpt_pkg::*;
(
   input  logic                   clock,
   input  logic [VALUE_WIDTH-1:0] value,
   input  tdpt_cmd_type           cmd,
   output tdpt_status_type        status
);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] divisor_ff, divisor_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;
   logic                   fits;

   // one restoring division bit per step
   assign trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      value_in   = value_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      count_in   = count_ff;
      if (cmd.load) begin
         value_in   = value;
         divisor_in = VALUE_WIDTH'(2);
         rem_in     = '0;
         quo_in     = value;
         count_in   = '0;
      end else if (cmd.next) begin
         divisor_in = divisor_ff + VALUE_WIDTH'(1);
         rem_in     = '0;
         quo_in     = value_ff;
         count_in   = '0;
      end else if (cmd.step) begin
         rem_in   = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
         quo_in   = {quo_ff[VALUE_WIDTH-2:0], fits};
         count_in = count_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      count_ff   <= count_in;
   end

   assign status.trivial_no = value_ff[VALUE_WIDTH-1] || (value_ff < VALUE_WIDTH'(2));
   assign status.div_last   = count_ff == COUNT_WIDTH'(VALUE_WIDTH - 1);
   assign status.bound_fail = divisor_ff > quo_ff;
   assign status.rem_zero   = rem_ff == '0;

endmodule

>>> rtl/tdpt_ctrl.sv
module tdpt_ctrl
   import tdpt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output logic            rsp_strobe,
   output logic            rsp_is_prime,
   output tdpt_cmd_type    cmd,
   input  tdpt_status_type status
);

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StCheck = 2'd1;
   localparam logic [1:0] StDiv   = 2'd2;
   localparam logic [1:0] StEval  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;
   logic       prime_ff, prime_in;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      prime_in  = prime_ff;
      cmd       = '0;
      unique case (state_ff)
         StIdle: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = StCheck;
            end
         end
         StCheck: begin
            if (status.trivial_no) begin
               strobe_in = 1'b1;
               prime_in  = 1'b0;
               state_in  = StIdle;
            end else begin
               state_in = StDiv;
            end
         end
         StDiv: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = StEval;
            end
         end
         StEval: begin
            if (status.bound_fail) begin
               strobe_in = 1'b1;
               prime_in  = 1'b1;
               state_in  = StIdle;
            end else if (status.rem_zero) begin
               strobe_in = 1'b1;
               prime_in  = 1'b0;
               state_in  = StIdle;
            end else begin
               cmd.next = 1'b1;
               state_in = StDiv;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StIdle;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      prime_ff <= prime_in;
   end

   assign busy         = state_ff != StIdle;
   assign rsp_strobe   = strobe_ff;
   assign rsp_is_prime = prime_ff;

endmodule

>>> rtl/trial_division_prime_test.sv
// channel   ports                        beat marked by
// request   req_value[31:0] signed       start && !busy
// result    rsp_is_prime                 rsp_strobe, one cycle
//
// a value below two, negative values included, is rejected in the check state without division;
// otherwise each trial divisor 2, 3, ... runs a full restoring division and then an evaluation state,
// all on the one-bit-per-cycle restoring divider shared by all trials
// synchronous active-high reset clears the controller state and strobe; busy stays high until the
// result beat; the receiver cannot stall, so the result is shown for one cycle only
module trial_division_prime_test
   import tdpt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_strobe,
   output logic                          rsp_is_prime
);

   tdpt_cmd_type    cmd;
   tdpt_status_type status;

   tdpt_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .rsp_strobe   (rsp_strobe),
      .rsp_is_prime (rsp_is_prime),
      .cmd          (cmd),
      .status       (status)
   );

   tdpt_datapath u_datapath (
      .clock  (clock),
      .value  (req_value),
      .cmd    (cmd),
      .status (status)
   );

endmodule

>>> verif/prime_verdict_checker.sv
`timescale 1ns / 100ps

module prime_verdict_checker
   import tdpt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   input  logic                          rsp_strobe,
   input  logic                          rsp_is_prime,
   output int                            errors,
   output int                            outstanding
);

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          is_prime;
   } verdict_type;

   verdict_type pending_verdicts[$];
   int          mismatch_count = 0;

   function automatic logic primality_of(input logic [VALUE_WIDTH-1:0] value);
      longint unsigned candidate;
      longint unsigned divisor;
      candidate = value;
      if (value[VALUE_WIDTH-1]) begin
         return 1'b0;
      end
      if (candidate < 2) begin
         return 1'b0;
      end
      for (divisor = 2; divisor <= candidate / divisor; divisor++) begin
         if (candidate % divisor == 0) begin
            return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      verdict_type oldest;
      verdict_type fresh;
      if (!reset) begin
         // result beat first, so a beat at the same edge never meets its own request
         if (rsp_strobe) begin
            if (pending_verdicts.size() == 0) begin
               $display("%t result beat with nothing expected: expected none, got is_prime %0b",
                        $time, rsp_is_prime);
               mismatch_count++;
            end else begin
               oldest = pending_verdicts.pop_front();
               if (rsp_is_prime !== oldest.is_prime) begin
                  $display("%t is_prime for %0d: expected %0b, got %0b",
                           $time, oldest.value, oldest.is_prime, rsp_is_prime);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            fresh.value    = req_value;
            fresh.is_prime = primality_of(req_value);
            pending_verdicts.push_back(fresh);
         end
      end
      errors      <= mismatch_count;
      outstanding <= pending_verdicts.size();
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tdpt_pkg::*;

   localparam int WATCHDOG_LIMIT = 8_000_000;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic                          rsp_strobe;
   logic                          rsp_is_prime;
   int                            errors;
   int                            outstanding;
   int                            idle_pct;
   int                            quiet_cycles;
   int                            phase;
   int                            phase_idle_pct[4] = '{0, 64, 0, 22};

   logic signed [VALUE_WIDTH-1:0] corner_values[$] = '{
      0, 1, 2, 3, 4, 5, -1, -2, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_fffe,
      32'sh7fff_fffd, 32'sh4000_0000, 9, 25, 49, 97, 121, 63001, 65521, 65535,
      1000003, 999999, 32767
   };

   trial_division_prime_test dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_is_prime (rsp_is_prime)
   );

   prime_verdict_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .rsp_strobe   (rsp_strobe),
      .rsp_is_prime (rsp_is_prime),
      .errors       (errors),
      .outstanding  (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[trial_division_prime_test] ERROR");
            $finish;
         end
      end
   end

   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      int          factors[11] = '{2, 3, 5, 7, 11, 13, 101, 251, 257, 509, 1021};
      int          pick;
      logic [31:0] raw;
      pick = $urandom_range(0, 99);
      raw  = $urandom;
      if (pick < 40) begin
         return $urandom_range(0, 4095);
      end else if (pick < 55) begin
         return $urandom_range(4096, 65535);
      end else if (pick < 65) begin
         return $urandom_range(65536, 1 << 20);
      end else if (pick < 75) begin
         // negative values of every shape
         return {1'b1, raw[30:0]};
      end else if (pick < 85) begin
         // large positive with a small factor keeps the divider short
         return {1'b0, raw[30:1], 1'b0};
      end else if (pick < 90) begin
         return 3 * $urandom_range(1, 715827882);
      end else begin
         return factors[$urandom_range(0, 10)] * factors[$urandom_range(0, 10)];
      end
   endfunction

   task automatic send_value(input logic signed [VALUE_WIDTH-1:0] value);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      reset        = 1'b1;
      start        = 1'b0;
      req_value    = '0;
      idle_pct     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (corner_values[i]) begin
         send_value(corner_values[i]);
      end
      for (phase = 0; phase < 4; phase++) begin
         // sender holds off until every verdict is back
         drain_results();
         idle_pct = phase_idle_pct[phase];
         repeat (19) send_value(random_value());
      end
      drain_results();
      repeat (64) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("[trial_division_prime_test] OK");
      end else begin
         $display("[trial_division_prime_test] ERROR");
      end
      $finish;
   end

endmodule

>>> trial_division_prime_test.f
rtl/tdpt_pkg.sv
rtl/tdpt_datapath.sv
rtl/tdpt_ctrl.sv
rtl/trial_division_prime_test.sv
verif/prime_verdict_checker.sv
verif/testbench.sv
